>>> src/chained_hash_table_int_macros.svh
// assertion macros for the chained hash table checker
// no dependencies; taken in by the checker file
`ifndef CHAINED_HASH_TABLE_INT_MACROS_SVH
`define CHAINED_HASH_TABLE_INT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define CHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/cht_pkg.sv
// shared types and constants of the chained hash table
// no dependencies
package cht_pkg;

   localparam logic [30:0] HASH_PRIME = 31'h7FFF_FFFF;

   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_DELETE   = 2'd1;
   localparam logic [1:0] OP_SEARCH   = 2'd2;
   // operation three acts as a search
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic [1:0] REG_HASH_MULT    = 2'd0;
   localparam logic [1:0] REG_HASH_ADD     = 2'd1;
   localparam logic [1:0] REG_BUCKET_COUNT = 2'd2;

   localparam int CSR_ADDR_W = 4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [30:0] key;
   } req_type;

   typedef struct packed {
      logic [3:0] position;
      logic       found;
      logic       chain_full;
      logic [5:0] bucket;
   } rsp_type;

   typedef enum logic [2:0] {
      HS_IDLE,
      HS_MUL,
      HS_ADD,
      HS_FOLD1,
      HS_FOLD2,
      HS_SUB,
      HS_DIV,
      HS_DONE
   } hash_state_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_FILL_RD,
      ST_FILL_GET,
      ST_WALK,
      ST_CMP,
      ST_SHIFT,
      ST_SHIFT_WR,
      ST_RESP
   } ctrl_state_type;

endpackage

>>> src/cht_hash.sv
// iterative bucket hash: multiply, add, reduce mod 2^31-1, then bit-serial mod bucket count
// depends on cht_pkg
module cht_hash #(
   parameter int MAX_BUCKETS = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [30:0]                             key,
   input  logic [30:0]                             mult,
   input  logic [30:0]                             add,
   input  logic [$clog2(MAX_BUCKETS+1)-1:0]        nbuck,
   output logic                                    done,
   output logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] bucket
);

   localparam int NW = $clog2(MAX_BUCKETS + 1);
   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

   cht_pkg::hash_state_type state_ff, state_in;
   logic [62:0]   acc_ff, acc_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [NW:0]   trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cht_pkg::HS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      trial    = {rem_ff, acc_ff[30]};
      case (state_ff)
         cht_pkg::HS_IDLE: begin
            if (start) begin
               state_in = cht_pkg::HS_MUL;
            end
         end
         cht_pkg::HS_MUL: begin
            acc_in   = {1'b0, 62'(mult) * 62'(key)};
            state_in = cht_pkg::HS_ADD;
         end
         cht_pkg::HS_ADD: begin
            acc_in   = acc_ff + 63'(add);
            state_in = cht_pkg::HS_FOLD1;
         end
         cht_pkg::HS_FOLD1: begin
            // 2^31 is 1 mod the prime, so high part folds onto low part
            acc_in   = 63'(33'(acc_ff[62:31]) + 33'(acc_ff[30:0]));
            state_in = cht_pkg::HS_FOLD2;
         end
         cht_pkg::HS_FOLD2: begin
            acc_in   = 63'(32'(acc_ff[32:31]) + 32'(acc_ff[30:0]));
            state_in = cht_pkg::HS_SUB;
         end
         cht_pkg::HS_SUB: begin
            if (acc_ff[31:0] >= 32'(cht_pkg::HASH_PRIME)) begin
               acc_in = acc_ff - 63'(cht_pkg::HASH_PRIME);
            end
            rem_in   = '0;
            cnt_in   = '0;
            state_in = cht_pkg::HS_DIV;
         end
         cht_pkg::HS_DIV: begin
            // restoring division, one quotient bit per cycle
            if (trial >= (NW+1)'(nbuck)) begin
               rem_in = NW'(trial - (NW+1)'(nbuck));
            end else begin
               rem_in = trial[NW-1:0];
            end
            acc_in = {acc_ff[61:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd30) begin
               state_in = cht_pkg::HS_DONE;
            end
         end
         cht_pkg::HS_DONE: begin
            state_in = cht_pkg::HS_IDLE;
         end
         default: begin
            state_in = cht_pkg::HS_IDLE;
         end
      endcase
   end

   assign done   = (state_ff == cht_pkg::HS_DONE);
   assign bucket = rem_ff[BW-1:0];

endmodule

>>> src/chained_hash_table_int.sv
// top level of the chained hash table: config registers, sequencer, chain and fill memories
// depends on cht_pkg and cht_hash
//
// Integer hash table with separate chaining. Each item (insert, delete or search)
// runs alone: it is hashed in the shared unit (one 31x31 multiply, an add, two folds
// and a subtract modulo 2^31-1, then a 31-step bit-serial remainder by the bucket
// count), the bucket's fill count is read (ST_FILL_RD, ST_FILL_GET), for a search or
// delete each chain entry is walked (ST_WALK, ST_CMP) through the entry memory, which
// has one read and one write port, until a hit or the end of the chain, on delete
// each later entry is moved forward (ST_SHIFT, ST_SHIFT_WR), and the result is handed
// off once the previous result no longer waits on rsp_stall. After reset the fill
// counts are cleared one bucket at a time before the first item is taken; register
// writes are taken at any time.
module chained_hash_table_int #(
   parameter int MAX_BUCKETS = 64,
   parameter int CHAIN_DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  cht_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output cht_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cht_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   localparam int NW = $clog2(MAX_BUCKETS + 1);
   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int SW = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
   localparam int FW = $clog2(CHAIN_DEPTH + 1);
   localparam int PW = (FW > 4) ? FW : 4;
   localparam int OW = (BW > 6) ? BW : 6;
   localparam int ENT_DEPTH = MAX_BUCKETS * (2 ** SW);

   // configuration registers
   logic [30:0] mult_ff, add_ff;
   logic [6:0]  bcnt_ff;
   logic        csr_wr;

   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff <= 31'd1;
         add_ff  <= 31'd0;
         bcnt_ff <= 7'd64;
      end else if (csr_wr) begin
         case (paddr[3:2])
            cht_pkg::REG_HASH_MULT:    mult_ff <= pwdata[30:0];
            cht_pkg::REG_HASH_ADD:     add_ff  <= pwdata[30:0];
            cht_pkg::REG_BUCKET_COUNT: bcnt_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         cht_pkg::REG_HASH_MULT:    prdata = {1'b0, mult_ff};
         cht_pkg::REG_HASH_ADD:     prdata = {1'b0, add_ff};
         cht_pkg::REG_BUCKET_COUNT: prdata = {25'd0, bcnt_ff};
         default:                   prdata = '0;
      endcase
   end

   // effective bucket count, clamped to 1..MAX_BUCKETS
   logic [NW-1:0] nbuck;
   always_comb begin
      if (bcnt_ff == 7'd0) begin
         nbuck = NW'(1);
      end else if (32'(bcnt_ff) > 32'(MAX_BUCKETS)) begin
         nbuck = NW'(MAX_BUCKETS);
      end else begin
         nbuck = NW'(bcnt_ff);
      end
   end

   // sequencer state
   cht_pkg::ctrl_state_type state_ff, state_in;
   logic            rsp_valid_ff;
   cht_pkg::rsp_type rsp_ff, rsp_in;
   logic [1:0]      op_ff;
   logic [30:0]     key_ff;
   logic [BW-1:0]   bucket_ff, bucket_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [FW-1:0]   idx_ff, idx_in;
   logic [FW-1:0]   pos_ff, pos_in;
   logic            found_ff, found_in;
   logic            full_ff, full_in;
   logic [BW-1:0]   clr_ff, clr_in;
   logic            accept, rsp_load;

   // hash unit
   logic            hash_done;
   logic [BW-1:0]   hash_bucket;

   cht_hash #(.MAX_BUCKETS(MAX_BUCKETS)) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .key    (key_ff),
      .mult   (mult_ff),
      .add    (add_ff),
      .nbuck  (nbuck),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   // fill count memory
   logic [FW-1:0] fill_mem [MAX_BUCKETS];
   logic [FW-1:0] fill_rd_ff;
   logic          fill_we;
   logic [BW-1:0] fill_waddr;
   logic [FW-1:0] fill_wdata;

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      fill_rd_ff <= fill_mem[bucket_ff];
   end

   // chain entry memory, addressed by bucket and slot
   logic [30:0]      ent_mem [ENT_DEPTH];
   logic [30:0]      ent_rd_ff;
   logic             ent_we;
   logic [BW+SW-1:0] ent_waddr, ent_raddr;
   logic [30:0]      ent_wdata;

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_rd_ff <= ent_mem[ent_raddr];
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != cht_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cht_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         op_ff  <= req_data.operation;
         key_ff <= req_data.key;
      end
      rsp_ff    <= rsp_in;
      bucket_ff <= bucket_in;
      fill_ff   <= fill_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      found_ff  <= found_in;
      full_ff   <= full_in;
   end

   logic [PW-1:0] pos_w;
   logic [OW-1:0] bucket_w;
   logic [FW:0]   idx_next;

   assign pos_w    = PW'(pos_ff);
   assign bucket_w = OW'(bucket_ff);
   assign idx_next = (FW+1)'(idx_ff) + (FW+1)'(1);

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      bucket_in  = bucket_ff;
      fill_in    = fill_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      found_in   = found_ff;
      full_in    = full_ff;
      rsp_in     = rsp_ff;
      rsp_load   = 1'b0;
      fill_we    = 1'b0;
      fill_waddr = bucket_ff;
      fill_wdata = '0;
      ent_we     = 1'b0;
      ent_waddr  = {bucket_ff, idx_ff[SW-1:0]};
      ent_wdata  = key_ff;
      ent_raddr  = {bucket_ff, idx_ff[SW-1:0]};
      case (state_ff)
         cht_pkg::ST_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            clr_in     = clr_ff + BW'(1);
            if (clr_ff == BW'(MAX_BUCKETS - 1)) begin
               state_in = cht_pkg::ST_IDLE;
            end
         end
         cht_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = cht_pkg::ST_HASH;
            end
         end
         cht_pkg::ST_HASH: begin
            if (hash_done) begin
               bucket_in = hash_bucket;
               state_in  = cht_pkg::ST_FILL_RD;
            end
         end
         cht_pkg::ST_FILL_RD: begin
            state_in = cht_pkg::ST_FILL_GET;
         end
         cht_pkg::ST_FILL_GET: begin
            fill_in  = fill_rd_ff;
            idx_in   = '0;
            found_in = 1'b0;
            full_in  = 1'b0;
            pos_in   = fill_rd_ff;
            if (op_ff == cht_pkg::OP_INSERT) begin
               if (32'(fill_rd_ff) >= 32'(CHAIN_DEPTH)) begin
                  full_in = 1'b1;
               end else begin
                  ent_we     = 1'b1;
                  ent_waddr  = {bucket_ff, fill_rd_ff[SW-1:0]};
                  fill_we    = 1'b1;
                  fill_wdata = fill_rd_ff + FW'(1);
               end
               state_in = cht_pkg::ST_RESP;
            end else begin
               state_in = cht_pkg::ST_WALK;
            end
         end
         cht_pkg::ST_WALK: begin
            if (idx_ff == fill_ff) begin
               pos_in   = fill_ff;
               state_in = cht_pkg::ST_RESP;
            end else begin
               state_in = cht_pkg::ST_CMP;
            end
         end
         cht_pkg::ST_CMP: begin
            if (ent_rd_ff == key_ff) begin
               found_in = 1'b1;
               pos_in   = idx_ff;
               if (op_ff == cht_pkg::OP_DELETE) begin
                  state_in = cht_pkg::ST_SHIFT;
               end else begin
                  state_in = cht_pkg::ST_RESP;
               end
            end else begin
               idx_in   = idx_next[FW-1:0];
               state_in = cht_pkg::ST_WALK;
            end
         end
         cht_pkg::ST_SHIFT: begin
            // move later entries forward one slot
            if (idx_next < (FW+1)'(fill_ff)) begin
               ent_raddr = {bucket_ff, idx_next[SW-1:0]};
               state_in  = cht_pkg::ST_SHIFT_WR;
            end else begin
               fill_we    = 1'b1;
               fill_wdata = fill_ff - FW'(1);
               state_in   = cht_pkg::ST_RESP;
            end
         end
         cht_pkg::ST_SHIFT_WR: begin
            ent_we    = 1'b1;
            ent_wdata = ent_rd_ff;
            idx_in    = idx_next[FW-1:0];
            state_in  = cht_pkg::ST_SHIFT;
         end
         cht_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load          = 1'b1;
               rsp_in.position   = pos_w[3:0];
               rsp_in.found      = found_ff;
               rsp_in.chain_full = full_ff;
               rsp_in.bucket     = bucket_w[5:0];
               state_in          = cht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cht_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/cht_checker.sv
// port-level checker for the chained hash table, bound to the top level
// depends on cht_pkg and chained_hash_table_int_macros.svh
`include "chained_hash_table_int_macros.svh"

module cht_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cht_pkg::rsp_type rsp_data
);

   // a result waiting on the far side holds still
   `CHT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // one item at a time: taking an item closes the input
   `CHT_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall)

   // a dropped insert never reports a hit
   `CHT_ASSERT_NOW(a_full_no_hit, clock, reset, rsp_valid && rsp_data.chain_full, !rsp_data.found)

   // a result never shows up the cycle after an item is taken
   `CHT_ASSERT_NEXT(a_no_instant, clock, reset, req_valid && !req_stall && !rsp_valid, !rsp_valid)

endmodule

bind chained_hash_table_int cht_checker u_cht_checker (.*);

>>> tb/hash_table_checker.sv
// checker for the chained hash table: predicts each result from accepted items
// depends on cht_pkg; instantiated by testbench beside the block
`timescale 1ns / 100ps

module hash_table_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  cht_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  cht_pkg::rsp_type rsp_data,
   input  logic             cfg_write,
   input  logic [1:0]       cfg_index,
   input  logic [31:0]      cfg_value,
   output int               fail_count,
   output int               pending_count
);

   localparam int NUM_BUCKETS = 64;
   localparam int DEPTH = 8;

   logic [30:0]      table_keys [NUM_BUCKETS][DEPTH];
   int               table_fill [NUM_BUCKETS];
   logic [30:0]      mult_reg, add_reg;
   logic [6:0]       count_reg;
   cht_pkg::rsp_type expected_rsps [$];

   function automatic int bucket_for(logic [30:0] key);
      longint unsigned h;
      int n;
      n = count_reg;
      if (n == 0) n = 1;
      if (n > NUM_BUCKETS) n = NUM_BUCKETS;
      h = (longint'(mult_reg) * longint'(key) + longint'(add_reg)) % 64'd2147483647;
      return int'(h % n);
   endfunction

   task automatic apply_op(cht_pkg::req_type item);
      cht_pkg::rsp_type r;
      int b, fill, pos;
      b = bucket_for(item.key);
      fill = table_fill[b];
      r = '0;
      r.bucket = b[5:0];
      if (item.operation == cht_pkg::OP_INSERT) begin
         pos = fill;
         if (fill >= DEPTH) begin
            r.chain_full = 1'b1;
         end else begin
            table_keys[b][fill] = item.key;
            table_fill[b] = fill + 1;
         end
      end else begin
         pos = 0;
         while (pos < fill && table_keys[b][pos] != item.key) pos++;
         r.found = pos < fill;
         if (item.operation == cht_pkg::OP_DELETE && pos < fill) begin
            for (int i = pos; i + 1 < fill; i++) table_keys[b][i] = table_keys[b][i + 1];
            table_fill[b] = fill - 1;
         end
      end
      r.position = pos[3:0];
      expected_rsps.insert(expected_rsps.size(), r);
   endtask

   always @(posedge clock) begin
      cht_pkg::rsp_type want;
      if (reset) begin
         foreach (table_fill[i]) table_fill[i] = 0;
         mult_reg = 31'd1;
         add_reg = 31'd0;
         count_reg = 7'd64;
         expected_rsps.delete();
         fail_count = 0;
         pending_count = 0;
      end else begin
         if (cfg_write) begin
            case (cfg_index)
               cht_pkg::REG_HASH_MULT: mult_reg = cfg_value[30:0];
               cht_pkg::REG_HASH_ADD: add_reg = cfg_value[30:0];
               cht_pkg::REG_BUCKET_COUNT: count_reg = cfg_value[6:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) apply_op(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (want !== rsp_data) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
         pending_count = expected_rsps.size();
      end
   end
endmodule

>>> tb/testbench.sv
// top of the chained hash table testbench: clock, reset, stimulus and verdict
// depends on cht_pkg, chained_hash_table_int and hash_table_checker
`timescale 1ns / 100ps

module testbench;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   cht_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   cht_pkg::rsp_type rsp_data;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [cht_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count, pending_count;
   int          send_idle = 33, recv_idle = 83;
   logic [30:0] key_pool [16];

   wire cfg_write = psel && penable && pwrite && pready;

   chained_hash_table_int i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   hash_table_checker i_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .cfg_write, .cfg_index(paddr[3:2]), .cfg_value(pwdata),
      .fail_count, .pending_count
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   initial begin
      #50ms;
      $display("simulation failed");
      $finish;
   end

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= {index, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      @(posedge clock);
   endtask

   // valid stays up after the item is taken until the next call or drain
   task automatic send_item(logic [1:0] op, logic [30:0] key);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{operation: op, key: key};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // wait for outstanding results, then idle a while
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic random_items(int count);
      logic [30:0] k;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = int'($urandom_range(9));
         if (pick < 7) k = key_pool[$urandom_range(15)];
         else if (pick == 7) k = 31'(31'h7FFF_FFFE - $urandom_range(3));
         else k = 31'($urandom_range(31'h7FFF_FFFE));
         send_item($urandom_range(99) < 45 ? cht_pkg::OP_INSERT : 2'($urandom_range(3)), k);
      end
   endtask

   initial begin
      foreach (key_pool[i]) key_pool[i] = 31'($urandom_range(31'h7FFF_FFFE));
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extreme keys, full chain, duplicates, delete shifts, op three
      send_item(cht_pkg::OP_INSERT, 31'd0);
      send_item(cht_pkg::OP_INSERT, 31'h7FFF_FFFE);
      for (int i = 0; i < 9; i++) send_item(cht_pkg::OP_INSERT, 31'(64 * i + 5));
      send_item(cht_pkg::OP_INSERT, 31'd69);
      send_item(cht_pkg::OP_SEARCH, 31'd69);
      send_item(cht_pkg::OP_DELETE, 31'd133);
      send_item(cht_pkg::OP_SEARCH, 31'd197);
      send_item(cht_pkg::OP_RESERVED, 31'd7);
      send_item(cht_pkg::OP_DELETE, 31'd999);
      send_item(cht_pkg::OP_SEARCH, 31'h7FFF_FFFE);
      send_item(cht_pkg::OP_DELETE, 31'd0);
      send_item(cht_pkg::OP_DELETE, 31'd0);
      drain();

      write_reg(cht_pkg::REG_HASH_MULT, 32'h7FFF_FFFF);
      write_reg(cht_pkg::REG_HASH_ADD, 32'h7FFF_FFFE);
      write_reg(cht_pkg::REG_BUCKET_COUNT, 32'd1);
      random_items(150);
      drain();

      send_idle = 83; recv_idle = 33;
      write_reg(cht_pkg::REG_HASH_MULT, 32'd0);
      write_reg(cht_pkg::REG_BUCKET_COUNT, 32'd0);
      random_items(40);
      drain();
      write_reg(cht_pkg::REG_HASH_MULT, $urandom_range(32'h7FFF_FFFF, 1));
      write_reg(cht_pkg::REG_HASH_ADD, $urandom_range(32'h7FFF_FFFE));
      write_reg(cht_pkg::REG_BUCKET_COUNT, 32'd127);
      random_items(110);
      drain();

      send_idle = 0; recv_idle = 0;
      write_reg(cht_pkg::REG_HASH_MULT, $urandom_range(32'h7FFF_FFFF, 1));
      write_reg(cht_pkg::REG_HASH_ADD, 32'd0);
      write_reg(cht_pkg::REG_BUCKET_COUNT, 32'd7);
      random_items(150);
      drain();

      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
